// File: rtl/rdc_pkg.sv
// shared constants, types and digit mapping for the radix digit converter
`default_nettype none
package rdc_pkg;

	localparam int VALUE_BITS = 32;
	localparam int IN_W = 32;
	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam int RADIX_W = 6;
	localparam int CHAR_W = 7;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	// register index taken from paddr bit 2
	localparam logic REG_RADIX = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic                quo_zero;
		logic [RADIX_W-1:0]  rem;
	} div_stat_t;

	function automatic logic [CHAR_W-1:0] digit_char_of(input logic [RADIX_W-1:0] rem);
		logic [CHAR_W-1:0] r;
		r = {1'b0, rem};
		if (rem < 6'd10) begin
			return 7'd48 + r;
		end else begin
			return 7'd55 + r;
		end
	endfunction

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] v);
		if (v < RADIX_MIN) begin
			return RADIX_MIN;
		end else if (v > RADIX_MAX) begin
			return RADIX_MAX;
		end else begin
			return v;
		end
	endfunction

endpackage
`default_nettype wire

// File: rtl/rdc_if.sv
// valid/ready channel interfaces for values in and digits out
`default_nettype none
interface rdc_in_if import rdc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface rdc_out_if import rdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] digit_char;
	logic              last_digit;

	modport source (output valid, output digit_char, output last_digit, input ready);
	modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface
`default_nettype wire

// File: rtl/radix_digit_converter.sv
// top level: radix register, digit sequencer and output register
`default_nettype none
// Converts each 32-bit unsigned value to the base held in the radix register (2..36, reset
// 10, writes clamped into range) and sends its digits as ASCII '0'-'9','A'-'Z', least
// significant first, with last_digit on the most significant one; zero gives one '0'.
// One value is converted at a time. Digits are produced by the bit-serial divider, which
// retires one quotient bit per cycle over all 32 bits for each digit. The next division
// runs while a finished digit waits in the output register.
module radix_digit_converter import rdc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	rdc_in_if.sink                  din,
	rdc_out_if.source               dout,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output      logic [PDATA_W-1:0] prdata,
	output      logic               pready
);

	logic [RADIX_W-1:0]    radix_q;
	state_t                state_q;
	state_t                state_d;
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	logic                  accept;
	logic                  emit;
	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dividend;
	logic [VALUE_BITS-1:0] quotient;
	div_stat_t             stat;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_RADIX) begin
			radix_q <= clamp_radix(pwdata[RADIX_W-1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_RADIX) begin
			prdata = PDATA_W'(radix_q);
		end
	end

	// divider
	assign div_dividend = (state_q == ST_IDLE) ? din.value[VALUE_BITS-1:0] : quotient;

	rdc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.radix    (radix_q),
		.quotient (quotient),
		.stat     (stat)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (din.valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || dout.ready) begin
					state_d = stat.quo_zero ? ST_IDLE : ST_DIV;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		din.ready = 1'b0;
		emit      = 1'b0;
		case (state_q)
			ST_IDLE: din.ready = 1'b1;
			ST_EMIT: emit = !out_valid_q || dout.ready;
			default: begin
				din.ready = 1'b0;
				emit      = 1'b0;
			end
		endcase
	end

	assign accept    = din.valid && din.ready;
	// quotient of the digit just sent feeds the next division
	assign div_start = accept || (emit && !stat.quo_zero);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= digit_char_of(stat.rem);
			last_q <= stat.quo_zero;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.digit_char = char_q;
	assign dout.last_digit = last_q;

`ifndef SYNTHESIS
	a_accept_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !stat.busy)
		else $error("value accepted while divider busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside division state");

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> stat.rem < radix_q)
		else $error("remainder not below radix");

	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		radix_q >= RADIX_MIN && radix_q <= RADIX_MAX)
		else $error("radix out of range");

	a_emit_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !stat.quo_zero |=> stat.busy && state_q == ST_DIV)
		else $error("next digit division did not start");
`endif

endmodule
`default_nettype wire

// File: rtl/rdc_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module rdc_divider import rdc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] dividend,
	input  wire logic [RADIX_W-1:0]    radix,
	output      logic [VALUE_BITS-1:0] quotient,
	output      div_stat_t             stat
);

	logic [VALUE_BITS-1:0] quo_q;
	logic [RADIX_W-1:0]    rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  nz_q;

	logic [RADIX_W:0] trial;
	logic [RADIX_W:0] diff;
	logic             ge;

	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge    = trial >= {1'b0, radix};
	assign diff  = trial - {1'b0, radix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			nz_q  <= 1'b0;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
			nz_q  <= nz_q | ge;
		end
	end

	assign quotient      = quo_q;
	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.quo_zero = !nz_q;
	assign stat.rem      = rem_q;

endmodule
`default_nettype wire
